// ===== design/tpc_pkg.sv =====
// Shared constants and types for the touch point calibration block.
// No dependencies; used by tpc_axis and touch_point_calibrate.

package tpc_pkg;

    localparam int RAW_W   = 12;             // raw converter reading
    localparam int HALF_W  = RAW_W - 1;      // halved reading
    localparam int CAL_W   = 14;             // calibration window registers
    localparam int SIDE_W  = 12;             // panel sides and coordinates
    localparam int ORIENT_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = CAL_W;
    localparam int PROD_W  = HALF_W + SIDE_W; // product and quotient width
    localparam int MUL_STEPS = SIDE_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W   = $clog2(DIV_STEPS);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CAL_X_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_X_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE     = 3'd7;

    // orientation codes; anything else means no transform
    localparam logic [ORIENT_W-1:0] OR_PORTRAIT       = 3'd0;
    localparam logic [ORIENT_W-1:0] OR_PORTRAIT_FLIP  = 3'd1;
    localparam logic [ORIENT_W-1:0] OR_LANDSCAPE      = 3'd2;
    localparam logic [ORIENT_W-1:0] OR_LANDSCAPE_FLIP = 3'd3;

    // reset values
    localparam logic [CAL_W-1:0]  RST_CAL_LOW  = 14'd0;
    localparam logic [CAL_W-1:0]  RST_CAL_HIGH = 14'd2047;
    localparam logic [SIDE_W-1:0] RST_WIDTH    = 12'd240;
    localparam logic [SIDE_W-1:0] RST_HEIGHT   = 12'd320;

    // start request for one axis unit
    typedef struct packed {
        logic              start;
        logic [HALF_W-1:0] diff;     // reading minus low edge, zero if below it
        logic [SIDE_W-1:0] side;     // panel side for this axis, nonzero
        logic [CAL_W-1:0]  divisor;  // window span, nonzero
    } axis_req_t;

endpackage

// ===== design/tpc_axis.sv =====
// One calibration axis: bit-serial shift-add multiply, then restoring divide
// one quotient bit per cycle, then clamp to the panel side. Uses tpc_pkg.

module tpc_axis (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tpc_pkg::axis_req_t           req,
    output logic                         busy,
    output logic [tpc_pkg::SIDE_W-1:0]   result
);

    typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV} astate_t;

    astate_t                      state_reg, state_next;
    logic [tpc_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [tpc_pkg::PROD_W-1:0]   acc_reg, acc_next;
    logic [tpc_pkg::CAL_W-1:0]    rem_reg, rem_next;
    logic [tpc_pkg::HALF_W-1:0]   mcand_reg, mcand_next;
    logic [tpc_pkg::SIDE_W-1:0]   mplier_reg, mplier_next;
    logic [tpc_pkg::SIDE_W-1:0]   side_reg, side_next;
    logic [tpc_pkg::CAL_W-1:0]    div_reg, div_next;
    logic [tpc_pkg::SIDE_W-1:0]   res_reg, res_next;

    logic [tpc_pkg::CAL_W:0]      shifted;
    logic [tpc_pkg::CAL_W+1:0]    trial;
    logic                         qbit;
    logic [tpc_pkg::PROD_W-1:0]   quot;
    logic [tpc_pkg::SIDE_W-1:0]   limit;

    always_comb
    begin
        shifted = {rem_reg, acc_reg[tpc_pkg::PROD_W-1]};
        trial   = {1'b0, shifted} - {2'b00, div_reg};
        qbit    = ~trial[tpc_pkg::CAL_W+1];
        quot    = {acc_reg[tpc_pkg::PROD_W-2:0], qbit};
        limit   = side_reg - tpc_pkg::SIDE_W'(1);
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        side_next   = side_reg;
        div_next    = div_reg;
        res_next    = res_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    mcand_next  = req.diff;
                    mplier_next = req.side;
                    side_next   = req.side;
                    div_next    = req.divisor;
                    acc_next    = '0;
                    cnt_next    = tpc_pkg::CNT_W'(tpc_pkg::MUL_STEPS - 1);
                    state_next  = A_MUL;
                end
            end
            A_MUL:
            begin
                // MSB first: acc = 2*acc + bit*mcand
                acc_next = {acc_reg[tpc_pkg::PROD_W-2:0], 1'b0}
                         + (mplier_reg[tpc_pkg::SIDE_W-1]
                            ? tpc_pkg::PROD_W'(mcand_reg) : '0);
                mplier_next = {mplier_reg[tpc_pkg::SIDE_W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    cnt_next   = tpc_pkg::CNT_W'(tpc_pkg::DIV_STEPS - 1);
                    rem_next   = '0;
                    state_next = A_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - tpc_pkg::CNT_W'(1);
                end
            end
            A_DIV:
            begin
                // remainder stays below the divisor, so 14 bits hold it
                rem_next = qbit ? trial[tpc_pkg::CAL_W-1:0] : shifted[tpc_pkg::CAL_W-1:0];
                acc_next = quot;
                if (cnt_reg == '0)
                begin
                    res_next   = (quot > tpc_pkg::PROD_W'(limit)) ? limit
                                                                  : quot[tpc_pkg::SIDE_W-1:0];
                    state_next = A_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - tpc_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= A_IDLE;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            rem_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            side_reg   <= '0;
            div_reg    <= '0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            acc_reg    <= acc_next;
            rem_reg    <= rem_next;
            mcand_reg  <= mcand_next;
            mplier_reg <= mplier_next;
            side_reg   <= side_next;
            div_reg    <= div_next;
            res_reg    <= res_next;
        end
    end

    assign busy   = (state_reg != A_IDLE);
    assign result = res_reg;

`ifndef SYNTHESIS
    // clamped result never reaches the panel side
    a_res_in_side: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (res_reg < side_reg))
        else $error("axis result beyond panel side");

    // a start is only honored while idle, and leads straight into the multiply
    a_start_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && req.start) |=> (state_reg == A_MUL))
        else $error("axis did not start multiply");

    // restoring divide keeps the partial remainder below the divisor
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == A_DIV) |-> (rem_reg < div_reg))
        else $error("axis remainder not below divisor");
`endif

endmodule

// ===== design/touch_point_calibrate.sv =====
// Top level of the touch point calibration block: configuration registers,
// item sequencing, orientation transform and output register.
// Depends on tpc_pkg and tpc_axis.
//
//  channel   signals                             dir   payload
//  in        in_valid / in_ready                 in    touched, raw_x, raw_y
//  out       out_valid / out_ready               out   point_x, point_y, pressed
//  cfg       cfg_we, cfg_index, cfg_data         in    write only, no handshake
//
// One beat at a time. A calibrated touch is accepted, multiplied and then
// divided in the two serial axis units (both axes run side by side), handed
// off and finished. Raw-mode and untouched beats skip the axis units.
// in_ready rises again once the result sits in the output register; a
// stalled output holds the next finished result in the finish state.
// Reset clears held point, handshake state and restores register defaults.

module touch_point_calibrate (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              touched,
    input  logic [tpc_pkg::RAW_W-1:0]         raw_x,
    input  logic [tpc_pkg::RAW_W-1:0]         raw_y,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tpc_pkg::SIDE_W-1:0]        point_x,
    output logic [tpc_pkg::SIDE_W-1:0]        point_y,
    output logic                              pressed,
    input  logic                              cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_FIN} state_t;

    state_t                          state_reg, state_next;
    logic [tpc_pkg::CAL_W-1:0]       xl_reg, xr_reg, yt_reg, yb_reg;
    logic [tpc_pkg::SIDE_W-1:0]      pw_reg, ph_reg;
    logic [tpc_pkg::ORIENT_W-1:0]    orient_reg;
    logic                            raw_mode_reg;
    logic [tpc_pkg::RAW_W-1:0]       rx_reg, rx_next, ry_reg, ry_next;
    logic                            pass_reg, pass_next, calc_reg, calc_next;
    logic [tpc_pkg::SIDE_W-1:0]      held_x_reg, held_x_next, held_y_reg, held_y_next;
    logic                            out_valid_reg, out_valid_next;
    logic [tpc_pkg::SIDE_W-1:0]      out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic                            pressed_reg, pressed_next;

    logic [tpc_pkg::SIDE_W-1:0]      pw_eff, ph_eff, w_side, h_side, wm1, hm1;
    logic [tpc_pkg::HALF_W-1:0]      x_half, y_half;
    logic                            calc_ok;
    tpc_pkg::axis_req_t              x_req, y_req;
    logic                            x_busy, y_busy;
    logic [tpc_pkg::SIDE_W-1:0]      x_res, y_res, px_o, py_o, fin_x, fin_y;
    logic                            fin_ok, out_free;

    // panel sides: zero acts as one, width is the smaller side
    always_comb
    begin
        pw_eff = (pw_reg == '0) ? tpc_pkg::SIDE_W'(1) : pw_reg;
        ph_eff = (ph_reg == '0) ? tpc_pkg::SIDE_W'(1) : ph_reg;
        w_side = (pw_eff > ph_eff) ? ph_eff : pw_eff;
        h_side = (pw_eff > ph_eff) ? pw_eff : ph_eff;
        wm1    = w_side - tpc_pkg::SIDE_W'(1);
        hm1    = h_side - tpc_pkg::SIDE_W'(1);
    end

    always_comb
    begin
        x_half  = raw_x[tpc_pkg::RAW_W-1:1];
        y_half  = raw_y[tpc_pkg::RAW_W-1:1];
        calc_ok = touched && !raw_mode_reg && (xr_reg > xl_reg) && (yb_reg > yt_reg);

        // below the low edge the quotient clamps to zero, same as a zero numerator
        x_req.start   = in_valid && in_ready && calc_ok;
        x_req.diff    = (tpc_pkg::CAL_W'(x_half) < xl_reg) ? '0
                      : x_half - xl_reg[tpc_pkg::HALF_W-1:0];
        x_req.side    = w_side;
        x_req.divisor = xr_reg - xl_reg;

        y_req.start   = in_valid && in_ready && calc_ok;
        y_req.diff    = (tpc_pkg::CAL_W'(y_half) < yt_reg) ? '0
                      : y_half - yt_reg[tpc_pkg::HALF_W-1:0];
        y_req.side    = h_side;
        y_req.divisor = yb_reg - yt_reg;
    end

    tpc_axis u_axis_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (x_req),
        .busy   (x_busy),
        .result (x_res)
    );

    tpc_axis u_axis_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (y_req),
        .busy   (y_busy),
        .result (y_res)
    );

    // orientation transform
    always_comb
    begin
        px_o = x_res;
        py_o = y_res;
        case (orient_reg)
            tpc_pkg::OR_PORTRAIT:
            begin
                py_o = hm1 - y_res;
            end
            tpc_pkg::OR_PORTRAIT_FLIP:
            begin
                px_o = wm1 - x_res;
                py_o = hm1 - y_res;
            end
            tpc_pkg::OR_LANDSCAPE:
            begin
                px_o = hm1 - y_res;
                py_o = wm1 - x_res;
            end
            tpc_pkg::OR_LANDSCAPE_FLIP:
            begin
                px_o = hm1 - y_res;
                py_o = x_res;
            end
            default:
            begin
                px_o = x_res;
                py_o = y_res;
            end
        endcase
        fin_x  = pass_reg ? rx_reg : px_o;
        fin_y  = pass_reg ? ry_reg : py_o;
        fin_ok = (pass_reg || calc_reg) && (fin_x != '0);
    end

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        pass_next      = pass_reg;
        calc_next      = calc_reg;
        held_x_next    = held_x_reg;
        held_y_next    = held_y_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        pressed_next   = pressed_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rx_next    = raw_x;
                    ry_next    = raw_y;
                    pass_next  = touched && raw_mode_reg;
                    calc_next  = calc_ok;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (!calc_reg || !x_busy)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    if (fin_ok)
                    begin
                        held_x_next = fin_x;
                        held_y_next = fin_y;
                    end
                    out_x_next     = fin_ok ? fin_x : held_x_reg;
                    out_y_next     = fin_ok ? fin_y : held_y_reg;
                    pressed_next   = fin_ok;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= 1'b0;
            calc_reg      <= 1'b0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            out_valid_reg <= 1'b0;
            rx_reg        <= '0;
            ry_reg        <= '0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            pressed_reg   <= 1'b0;
            xl_reg        <= tpc_pkg::RST_CAL_LOW;
            xr_reg        <= tpc_pkg::RST_CAL_HIGH;
            yt_reg        <= tpc_pkg::RST_CAL_LOW;
            yb_reg        <= tpc_pkg::RST_CAL_HIGH;
            pw_reg        <= tpc_pkg::RST_WIDTH;
            ph_reg        <= tpc_pkg::RST_HEIGHT;
            orient_reg    <= tpc_pkg::OR_PORTRAIT;
            raw_mode_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            calc_reg      <= calc_next;
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
            out_valid_reg <= out_valid_next;
            rx_reg        <= rx_next;
            ry_reg        <= ry_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            pressed_reg   <= pressed_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tpc_pkg::REG_CAL_X_LEFT:   xl_reg <= cfg_data;
                    tpc_pkg::REG_CAL_X_RIGHT:  xr_reg <= cfg_data;
                    tpc_pkg::REG_CAL_Y_TOP:    yt_reg <= cfg_data;
                    tpc_pkg::REG_CAL_Y_BOTTOM: yb_reg <= cfg_data;
                    tpc_pkg::REG_PANEL_WIDTH:  pw_reg <= cfg_data[tpc_pkg::SIDE_W-1:0];
                    tpc_pkg::REG_PANEL_HEIGHT: ph_reg <= cfg_data[tpc_pkg::SIDE_W-1:0];
                    tpc_pkg::REG_ORIENTATION:  orient_reg <= cfg_data[tpc_pkg::ORIENT_W-1:0];
                    tpc_pkg::REG_RAW_MODE:     raw_mode_reg <= cfg_data[0];
                    default:                   raw_mode_reg <= raw_mode_reg;
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = out_x_reg;
    assign point_y   = out_y_reg;
    assign pressed   = pressed_reg;

`ifndef SYNTHESIS
    // both axis units share one schedule
    a_axes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        x_busy == y_busy)
        else $error("axis units out of step");

    // a pressed beat never carries an X of zero
    a_pressed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pressed) |-> (point_x != '0))
        else $error("pressed beat with zero X");

    // one beat in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second beat accepted while busy");

    // a released beat repeats the held point
    a_release_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free && !fin_ok) |=>
            (point_x == held_x_reg && point_y == held_y_reg && !pressed))
        else $error("released beat does not repeat held point");
`endif

endmodule
